@@ rtl/fsub_pkg.sv @@
// ----------------------------------------------------------------------------
// fsub_pkg
// Types and constants shared by the truncating single-precision subtractor.
// ----------------------------------------------------------------------------
package fsub_pkg;

  localparam int unsigned ExpBias = 127;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_NORM,
    ST_DONE
  } fsub_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic align;
    logic norm;
  } fsub_cmd_t;

endpackage

@@ rtl/fsub_datapath.sv @@
// ----------------------------------------------------------------------------
// fsub_datapath
// Unpack, align, subtract and repack stages for a minus b, one stage per
// command from the controller.
// ----------------------------------------------------------------------------
module fsub_datapath
  import fsub_pkg::*;
(
  input  logic        clk,
  input  fsub_cmd_t   cmd,
  input  logic [31:0] minuend_bits,
  input  logic [31:0] subtrahend_bits,
  output logic [31:0] difference_bits
);

  // Unpacked operands: exponent minus bias (10-bit signed), signed fraction
  logic signed [9:0]  exp_a, exp_b;
  logic signed [31:0] frac_a, frac_b;
  // Difference and its exponent
  logic signed [32:0] diff;
  logic signed [9:0]  exp_d;

  logic signed [9:0]  ea_in, eb_in;
  logic signed [31:0] fa_in, fb_in;
  logic               za, zb;
  logic signed [9:0]  ediff;
  logic [4:0]         sh;
  logic signed [31:0] fa_al, fb_al;
  logic [32:0]        mag;
  logic [5:0]         lead;
  logic [32:0]        norm_v;
  logic signed [11:0] biased;
  logic [22:0]        mant;

  // Unpack both operands
  always_comb begin
    za = (minuend_bits[30:0] == 31'd0);
    zb = (subtrahend_bits[30:0] == 31'd0);
    ea_in = $signed({2'b00, minuend_bits[30:23]}) - 10'sd127;
    eb_in = $signed({2'b00, subtrahend_bits[30:23]}) - 10'sd127;
    fa_in = $signed({2'b01, minuend_bits[22:0], 7'd0});
    fb_in = $signed({2'b01, subtrahend_bits[22:0], 7'd0});
    if (minuend_bits[31]) fa_in = -fa_in;
    if (subtrahend_bits[31]) fb_in = -fb_in;
    if (za) begin
      fa_in = '0;
      ea_in = zb ? 10'sd0 : eb_in;
    end
    if (zb) begin
      fb_in = '0;
      eb_in = za ? 10'sd0 : ea_in;
    end
  end

  // Align the smaller operand; halving and subtraction are registered on align
  always_comb begin
    ediff = (exp_a > exp_b) ? exp_a - exp_b : exp_b - exp_a;
    sh = (ediff > 10'sd31) ? 5'd31 : ediff[4:0];
    fa_al = frac_a;
    fb_al = frac_b;
    if (exp_a > exp_b) fb_al = frac_b >>> sh;
    else fa_al = frac_a >>> sh;
  end

  // Normalize and repack
  always_comb begin
    mag = diff[32] ? 33'(-diff) : 33'(diff);
    lead = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lead = 6'(i);
    end
    norm_v = mag << (6'd31 - lead);
    mant = norm_v[30:8];
    biased = 12'(exp_d) + 12'(lead) - 12'sd30 + 12'sd127;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exp_a  <= ea_in;
      exp_b  <= eb_in;
      frac_a <= fa_in;
      frac_b <= fb_in;
    end
    if (cmd.align) begin
      diff  <= 33'(fa_al >>> 1) - 33'(fb_al >>> 1);
      exp_d <= ((exp_a > exp_b) ? exp_a : exp_b) + 10'sd1;
    end
    if (cmd.norm) begin
      if (diff == 33'd0 || biased <= 12'sd0) difference_bits <= 32'd0;
      else if (biased >= 12'sd255) difference_bits <= {diff[32], 8'hFF, 23'd0};
      else difference_bits <= {diff[32], biased[7:0], mant};
    end
  end

endmodule

@@ rtl/fsub_ctrl.sv @@
// ----------------------------------------------------------------------------
// fsub_ctrl
// Sequencer: load, align and subtract, normalize, then strobe the result.
// ----------------------------------------------------------------------------
module fsub_ctrl
  import fsub_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output fsub_cmd_t cmd
);

  fsub_state_t state, state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Advance one step per cycle, waiting in idle until start
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        cmd.align = 1'b1;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        cmd.norm = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        done = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_start_align: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == ST_ALIGN) else $error("start not taken");
  a_done_seq: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.norm)) else $error("done without normalize");
  a_one_cmd: assert property (@(posedge clk)
    $onehot0({cmd.load, cmd.align, cmd.norm})) else $error("overlapping commands");
`endif

endmodule

@@ rtl/float32_subtract_truncating_top.sv @@
// ----------------------------------------------------------------------------
// float32_subtract_truncating_top
// Truncating single-precision subtractor, a minus b.
// ----------------------------------------------------------------------------
// Pulse start with both operands while busy is low; the operands are taken
// at that edge. After the align and normalize states, done is high for exactly
// one cycle with difference_bits valid; capture it then, though the register
// holds it until the next normalize. Each item runs unpack, align and
// subtract, normalize and strobe, and a new start is taken the cycle after done.
// Denormals count as normal, Inf/NaN are not special, underflow flushes to
// zero and overflow gives a signed infinity.
module float32_subtract_truncating_top
  import fsub_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] minuend_bits,
  input  logic [31:0] subtrahend_bits,
  output logic        done,
  output logic [31:0] difference_bits
);

  fsub_cmd_t cmd;

  fsub_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .cmd(cmd)
  );

  fsub_datapath u_dp (
    .clk(clk), .cmd(cmd), .minuend_bits(minuend_bits),
    .subtrahend_bits(subtrahend_bits), .difference_bits(difference_bits)
  );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the truncating single-precision subtractor against an in-bench
// predictor of a minus b: directed extremes and special cases, then random
// operand pairs under three idling patterns on the command side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import fsub_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] minuend_bits = '0;
  logic [31:0] subtrahend_bits = '0;
  logic        busy;
  logic        done;
  logic [31:0] difference_bits;

  logic [31:0] diff_expected[$];
  int          mismatch_count = 0;
  int          beat_count = 0;
  int          result_count = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;

  localparam int CycleLimit = 200000;

  float32_subtract_truncating_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .minuend_bits(minuend_bits), .subtrahend_bits(subtrahend_bits),
    .done(done), .difference_bits(difference_bits)
  );

  always #5 clk = ~clk;

  // Unpack one operand to exponent and signed fraction, hidden one at bit 30
  function automatic void fp_unpack(input logic [31:0] bits, output bit is_zero,
                                    output int exp_u, output longint frac);
    logic [7:0]  ef;
    logic [22:0] man;
    ef = bits[30:23];
    man = bits[22:0];
    is_zero = (ef == 8'd0) && (man == 23'd0);
    exp_u = is_zero ? 0 : int'(ef) - int'(ExpBias);
    frac = is_zero ? 64'sd0 : ((longint'(man) << 7) | 64'sh40000000);
    if (!is_zero && bits[31]) frac = -frac;
  endfunction

  // Arithmetic shift right, saturating at 31 places
  function automatic longint shift_floor(input longint v, input int s);
    if (s > 31) s = 31;
    return v >>> s;
  endfunction

  function automatic logic [31:0] predict_difference(input logic [31:0] a_bits,
                                                     input logic [31:0] b_bits);
    bit          az, bz;
    int          ae, be, e, p, biased;
    longint      af, bf, d, mag;
    logic [31:0] sign;
    logic [22:0] mant;
    fp_unpack(a_bits, az, ae, af);
    fp_unpack(b_bits, bz, be, bf);
    if (az) ae = be;
    if (bz) be = ae;
    if (ae > be) begin
      bf = shift_floor(bf, ae - be);
      e = ae;
    end else begin
      af = shift_floor(af, be - ae);
      e = be;
    end
    d = shift_floor(af, 1) - shift_floor(bf, 1);
    e = e + 1;
    if (d == 0) return 32'h0;
    sign = (d < 0) ? 32'h80000000 : 32'h0;
    mag = (d < 0) ? -d : d;
    p = 31;
    while (p > 0 && mag[p] == 1'b0) p--;
    if (p >= 23) mant = 23'(mag >> (p - 23));
    else mant = 23'(mag << (23 - p));
    biased = e - 30 + p + int'(ExpBias);
    if (biased <= 0) return 32'h0;
    if (biased >= 255) return sign | 32'h7F800000;
    return sign | (32'(biased) << 23) | 32'(mant);
  endfunction

  // Hold start until the beat is taken; drop it only while idling
  task automatic send_operands(input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    minuend_bits <= a;
    subtrahend_bits <= b;
    diff_expected.push_back(predict_difference(a, b));
    @(posedge clk);
    while (busy) @(posedge clk);
    beat_count++;
  endtask

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      result_count <= result_count + 1;
      if (diff_expected.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected result %h", difference_bits);
      end else begin
        if (difference_bits !== diff_expected[0]) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("mismatch: a-b expected %h got %h", diff_expected[0], difference_bits);
        end
        void'(diff_expected.pop_front());
      end
    end
  end

  // Drop start and wait until every expected result has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (diff_expected.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_float();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(5))
      0: v[30:23] = 8'd127 + 8'($urandom_range(6)) - 8'd3;
      1: v[30:23] = $urandom_range(1) ? 8'd0 : 8'd255;
      2: v = $urandom_range(1) ? 32'h0 : 32'h80000000;
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic [31:0] vals[12] = '{32'h0, 32'h80000000, 32'h3F800000, 32'hBF800000,
      32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001, 32'h007FFFFF, 32'h7F800000,
      32'h00800000, 32'h4B000000, 32'h3F800001};
    for (int i = 0; i < 12; i++) send_operands(vals[i], vals[(i * 5 + 3) % 12]);
    send_operands(32'h3F800000, 32'h3F800000);   // equal operands cancel
    send_operands(32'h7F7FFFFF, 32'hFF7FFFFF);   // overflow to infinity
    send_operands(32'h00800000, 32'h00800001);   // underflow flush
    send_operands(32'h4F000000, 32'h3F800000);   // long alignment
    send_operands(32'h4F000000, 32'hBF800000);   // long alignment, negative
    send_operands(32'hFFFFFFFF, 32'h00000000);
    send_operands(32'h00000000, 32'hFFFFFFFF);
    send_operands(32'h3FFFFFFF, 32'h3F800000);   // truncation of low bits
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) send_operands($urandom(), $urandom());
      else send_operands(random_float(), random_float());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 28;
    test_directed();
    test_random(180);
    // Pause the sender until everything has come back
    wait_drained();
    idle_pct = 82;
    test_random(180);
    idle_pct = 0;
    test_random(190);
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d subtractions: zeros, denormals, Inf/NaN patterns, long",
             beat_count);
    $display("alignment, cancellation, overflow and underflow; %0d results seen",
             result_count);
    if (mismatch_count == 0 && diff_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // End the run if the block stops answering
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
